[design/roi_mean_gray_strided_assert.svh]
// Assertion macros shared by the checker of the region mean gray block.
// Depends on nothing; include it by bare file name where assertions are written.
`ifndef ROI_MEAN_GRAY_STRIDED_ASSERT_SVH
`define ROI_MEAN_GRAY_STRIDED_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ROI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("roi check failed: same-cycle property");

// Consequent must hold in the cycle after the antecedent.
`define ROI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("roi check failed: next-cycle property");

`endif

[design/roi_pkg.sv]
// Shared types, constants and helper functions for the region mean gray block.
// Depends on nothing; roi_front, roi_queue, roi_back and the top level import it.
package roi_pkg;

   // Field and state widths
   localparam int SumW    = 28;
   localparam int TallyW  = 21;
   localparam int PhaseW  = 10;
   localparam int GrayW   = 8;
   localparam int SizeW   = 11;
   localparam int OffsW   = 10;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 11;

   // Register indexes of the control port
   localparam logic [CsrIdxW-1:0] CSR_FRAME_WIDTH   = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_FRAME_HEIGHT  = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_REGION_LEFT   = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_REGION_TOP    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_REGION_RIGHT  = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_REGION_BOTTOM = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_SAMPLE_STEP   = 3'd6;

   // Register reset values
   localparam logic [SizeW-1:0] RstFrameWidth   = 11'd320;
   localparam logic [SizeW-1:0] RstFrameHeight  = 11'd240;
   localparam logic [OffsW-1:0] RstRegionLeft   = 10'd0;
   localparam logic [OffsW-1:0] RstRegionTop    = 10'd0;
   localparam logic [SizeW-1:0] RstRegionRight  = 11'd320;
   localparam logic [SizeW-1:0] RstRegionBottom = 11'd240;
   localparam logic [OffsW-1:0] RstSampleStep   = 10'd1;

   // Luma weights, scaled by 256
   localparam logic [15:0] CoefRed   = 16'd76;
   localparam logic [15:0] CoefGreen = 16'd150;
   localparam logic [15:0] CoefBlue  = 16'd30;

   typedef struct packed {
      logic [SizeW-1:0] frame_width;
      logic [SizeW-1:0] frame_height;
      logic [OffsW-1:0] region_left;
      logic [OffsW-1:0] region_top;
      logic [SizeW-1:0] region_right;
      logic [SizeW-1:0] region_bottom;
      logic [OffsW-1:0] sample_step;
   } cfg_type;

   typedef struct packed {
      logic [SumW-1:0]   gray_sum;
      logic [TallyW-1:0] pixel_tally;
   } frame_total_type;

   // Weighted sum of the three colours, top byte kept
   function automatic logic [GrayW-1:0] gray_of(input logic [7:0] red,
                                                input logic [7:0] green,
                                                input logic [7:0] blue);
      logic [15:0] acc;
      acc = CoefRed * 16'(red) + CoefGreen * 16'(green) + CoefBlue * 16'(blue);
      return acc[15:8];
   endfunction

endpackage

[design/roi_if.sv]
// Valid/ready channel interfaces for pixel requests and frame results.
// Depends on nothing; used by the top level.
interface roi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       frame_start;

   modport source (output valid, output red, output green, output blue,
                   output frame_start, input ready);
   modport sink   (input valid, input red, input green, input blue,
                   input frame_start, output ready);
endinterface

interface roi_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  mean_gray;
   logic [20:0] sample_count;
   logic        region_empty;

   modport source (output valid, output mean_gray, output sample_count,
                   output region_empty, input ready);
   modport sink   (input valid, input mean_gray, input sample_count,
                   input region_empty, output ready);
endinterface

[design/roi_front.sv]
// Front end: raster position tracking, region/stride classification, gray
// accumulation and frame totals. Depends on roi_pkg.
module roi_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                      clock,
   input  logic                      reset,
   input  roi_pkg::cfg_type          cfg,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [7:0]                red,
   input  logic [7:0]                green,
   input  logic [7:0]                blue,
   input  logic                      frame_start,
   output logic                      tot_valid,
   input  logic                      tot_ready,
   output roi_pkg::frame_total_type  tot_data
);
   import roi_pkg::*;

   localparam int ColW = $clog2(MAX_WIDTH);
   localparam int RowW = $clog2(MAX_HEIGHT);
   localparam int XW   = ((ColW + 1 > SizeW) ? ColW + 1 : SizeW) + 1;
   localparam int YW   = ((RowW + 1 > SizeW) ? RowW + 1 : SizeW) + 1;
   localparam logic [XW-1:0] MaxW = XW'(MAX_WIDTH);
   localparam logic [YW-1:0] MaxH = YW'(MAX_HEIGHT);

   // Position and stride state
   logic [ColW-1:0]   col_ff, col_in;
   logic [RowW-1:0]   row_ff, row_in;
   logic [PhaseW-1:0] cphase_ff, cphase_in;
   logic [PhaseW-1:0] rphase_ff, rphase_in;

   // Classified pixel stage
   logic              s1_valid_ff;
   logic              s1_start_ff;
   logic              s1_hit_ff;
   logic              s1_last_ff;
   logic [GrayW-1:0]  s1_gray_ff;

   // Running totals
   logic [SumW-1:0]   sum_ff, sum_in;
   logic [TallyW-1:0] tally_ff, tally_in;

   logic              advance;
   logic              accept;
   logic [ColW-1:0]   col_eff;
   logic [RowW-1:0]   row_eff;
   logic [PhaseW-1:0] cphase_eff, rphase_eff;
   logic [PhaseW-1:0] cp, rp;
   logic [XW-1:0]     colx, width_c, fw;
   logic [YW-1:0]     rowx, height_c, fh;
   logic              in_x, in_y, hit;
   logic              col_wrap, row_last;
   logic [SumW-1:0]   base_sum;
   logic [TallyW-1:0] base_tally;

   function automatic logic [PhaseW-1:0] next_phase(input logic [PhaseW-1:0] phase,
                                                    input logic [PhaseW-1:0] step);
      logic [PhaseW:0] n;
      n = {1'b0, phase} + 1'b1;
      return (n >= {1'b0, step}) ? '0 : n[PhaseW-1:0];
   endfunction

   // Stall only when a frame total cannot be queued
   assign advance  = !(s1_valid_ff && s1_last_ff && !tot_ready);
   assign in_ready = advance;
   assign accept   = in_valid && advance;

   // Clamp frame size to 1..maximum
   always_comb begin
      fw = XW'(cfg.frame_width);
      fh = YW'(cfg.frame_height);
      if (fw == '0) begin
         width_c = XW'(1);
      end else if (fw > MaxW) begin
         width_c = MaxW;
      end else begin
         width_c = fw;
      end
      if (fh == '0) begin
         height_c = YW'(1);
      end else if (fh > MaxH) begin
         height_c = MaxH;
      end else begin
         height_c = fh;
      end
   end

   // Classify the incoming pixel and work out the next position
   always_comb begin
      col_eff    = frame_start ? '0 : col_ff;
      row_eff    = frame_start ? '0 : row_ff;
      cphase_eff = frame_start ? '0 : cphase_ff;
      rphase_eff = frame_start ? '0 : rphase_ff;
      colx       = XW'(col_eff);
      rowx       = YW'(row_eff);
      cp         = (colx == XW'(cfg.region_left)) ? '0 : cphase_eff;
      rp         = (rowx == YW'(cfg.region_top)) ? '0 : rphase_eff;
      in_x       = (colx >= XW'(cfg.region_left)) && (colx < XW'(cfg.region_right));
      in_y       = (rowx >= YW'(cfg.region_top)) && (rowx < YW'(cfg.region_bottom));
      hit        = in_x && in_y && (cp == '0) && (rp == '0);
      col_wrap   = (colx + 1'b1) >= width_c;
      row_last   = (rowx + 1'b1) >= height_c;

      cphase_in = next_phase(cp, cfg.sample_step);
      col_in    = ColW'(col_eff + 1'b1);
      row_in    = row_eff;
      rphase_in = rphase_eff;
      if (col_wrap) begin
         col_in    = '0;
         cphase_in = '0;
         if (row_last) begin
            row_in    = '0;
            rphase_in = '0;
         end else begin
            row_in    = RowW'(row_eff + 1'b1);
            rphase_in = next_phase(rp, cfg.sample_step);
         end
      end
   end

   // Advance position on each accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         cphase_ff <= '0;
         rphase_ff <= '0;
      end else if (accept) begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         cphase_ff <= cphase_in;
         rphase_ff <= rphase_in;
      end
   end

   // Register the classified pixel; it holds while the front end stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_start_ff <= frame_start;
         s1_hit_ff   <= hit;
         s1_last_ff  <= col_wrap && row_last;
         s1_gray_ff  <= gray_of(red, green, blue);
      end
   end

   // Accumulate gray and tally; frame start drops the partial totals
   always_comb begin
      base_sum   = s1_start_ff ? '0 : sum_ff;
      base_tally = s1_start_ff ? '0 : tally_ff;
      sum_in     = base_sum + (s1_hit_ff ? SumW'(s1_gray_ff) : '0);
      tally_in   = base_tally + TallyW'(s1_hit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         tally_ff <= '0;
      end else if (s1_valid_ff && advance) begin
         sum_ff   <= s1_last_ff ? '0 : sum_in;
         tally_ff <= s1_last_ff ? '0 : tally_in;
      end
   end

   assign tot_valid            = s1_valid_ff && s1_last_ff;
   assign tot_data.gray_sum    = sum_in;
   assign tot_data.pixel_tally = tally_in;

endmodule

[design/roi_queue.sv]
// Two-entry queue of frame totals between front end and divider.
// Depends on roi_pkg.
module roi_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   output logic                      push_ready,
   input  roi_pkg::frame_total_type  push_data,
   output logic                      pop_valid,
   input  logic                      pop_ready,
   output roi_pkg::frame_total_type  pop_data
);
   import roi_pkg::*;

   frame_total_type slot_ff [2];
   logic            wr_ptr_ff;
   logic            rd_ptr_ff;
   logic [1:0]      count_ff;
   logic            do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Store incoming totals
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

endmodule

[design/roi_back.sv]
// Back end: bit-serial restoring divider for the frame mean and the result
// output register. Depends on roi_pkg.
module roi_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tot_valid,
   output logic                      tot_ready,
   input  roi_pkg::frame_total_type  tot_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [7:0]                mean_gray,
   output logic [20:0]               sample_count,
   output logic                      region_empty
);
   import roi_pkg::*;

   localparam int StepW = $clog2(SumW);

   typedef enum logic [2:0] {
      BK_IDLE   = 3'b001,
      BK_DIVIDE = 3'b010,
      BK_HOLD   = 3'b100
   } back_state_type;

   back_state_type    state_ff, state_in;
   logic [SumW-1:0]   quo_ff;
   logic [TallyW-1:0] rem_ff;
   logic [TallyW-1:0] div_ff;
   logic [StepW-1:0]  step_ff;
   logic [GrayW-1:0]  mean_ff;
   logic [TallyW-1:0] count_ff;
   logic              empty_ff;

   logic [TallyW:0]   rem_sh;
   logic [TallyW:0]   diff;
   logic              ge;
   logic [SumW-1:0]   quo_in;
   logic [TallyW-1:0] rem_in;

   assign tot_ready    = (state_ff == BK_IDLE);
   assign out_valid    = (state_ff == BK_HOLD);
   assign mean_gray    = mean_ff;
   assign sample_count = count_ff;
   assign region_empty = empty_ff;

   // One quotient bit per cycle
   always_comb begin
      rem_sh = {rem_ff, quo_ff[SumW-1]};
      diff   = rem_sh - {1'b0, div_ff};
      ge     = rem_sh >= {1'b0, div_ff};
      rem_in = ge ? diff[TallyW-1:0] : rem_sh[TallyW-1:0];
      quo_in = {quo_ff[SumW-2:0], ge};
   end

   // Sequence: take totals, divide (skipped when the tally is zero), hold the result until taken
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (tot_valid) begin
               state_in = (tot_data.pixel_tally == '0) ? BK_HOLD : BK_DIVIDE;
            end
         end
         BK_DIVIDE: begin
            if (step_ff == '0) begin
               state_in = BK_HOLD;
            end
         end
         BK_HOLD: begin
            if (out_ready) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Divider datapath and result fields
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (tot_valid) begin
               quo_ff   <= tot_data.gray_sum;
               rem_ff   <= '0;
               div_ff   <= tot_data.pixel_tally;
               step_ff  <= StepW'(SumW - 1);
               count_ff <= tot_data.pixel_tally;
               empty_ff <= (tot_data.pixel_tally == '0);
               mean_ff  <= '0;
            end
         end
         BK_DIVIDE: begin
            quo_ff  <= quo_in;
            rem_ff  <= rem_in;
            step_ff <= step_ff - 1'b1;
            if (step_ff == '0) begin
               mean_ff <= quo_in[GrayW-1:0];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[design/roi_mean_gray_strided.sv]
// Top level of the region mean gray block: control registers, front end,
// total queue and divider. Depends on roi_pkg, roi_if, roi_front/queue/back.
//
//   channel   direction  handshake        contents
//   req_chan  in         valid/ready      red, green, blue, frame_start
//   rsp_chan  out        valid/ready      mean_gray, sample_count, region_empty
//   csr_*     in         write enable     index 0..6, data 11 bits
//
// One pixel is taken per cycle, but for the stall below; its gray value is
// registered, then summed. Each frame total is loaded into a one-bit-per-cycle
// divider; the result then holds until taken. Two totals can wait ahead
// of the divider; with them full the last pixel of a frame stalls requests.
// Synchronous reset clears position, totals and handshakes; no clearing pass.
module roi_mean_gray_strided #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   roi_req_if.sink                            req_chan,
   roi_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_en,
   input  logic [roi_pkg::CsrIdxW-1:0]        csr_index,
   input  logic [roi_pkg::CsrDataW-1:0]       csr_wdata
);
   import roi_pkg::*;

   cfg_type         cfg_ff;
   logic            tot_valid, tot_ready;
   frame_total_type tot_data;
   logic            q_valid, q_ready;
   frame_total_type q_data;

   // Control register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width   <= RstFrameWidth;
         cfg_ff.frame_height  <= RstFrameHeight;
         cfg_ff.region_left   <= RstRegionLeft;
         cfg_ff.region_top    <= RstRegionTop;
         cfg_ff.region_right  <= RstRegionRight;
         cfg_ff.region_bottom <= RstRegionBottom;
         cfg_ff.sample_step   <= RstSampleStep;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:   cfg_ff.frame_width   <= csr_wdata;
            CSR_FRAME_HEIGHT:  cfg_ff.frame_height  <= csr_wdata;
            CSR_REGION_LEFT:   cfg_ff.region_left   <= csr_wdata[OffsW-1:0];
            CSR_REGION_TOP:    cfg_ff.region_top    <= csr_wdata[OffsW-1:0];
            CSR_REGION_RIGHT:  cfg_ff.region_right  <= csr_wdata;
            CSR_REGION_BOTTOM: cfg_ff.region_bottom <= csr_wdata;
            CSR_SAMPLE_STEP:   cfg_ff.sample_step   <= csr_wdata[OffsW-1:0];
            default: begin
            end
         endcase
      end
   end

   roi_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .red         (req_chan.red),
      .green       (req_chan.green),
      .blue        (req_chan.blue),
      .frame_start (req_chan.frame_start),
      .tot_valid   (tot_valid),
      .tot_ready   (tot_ready),
      .tot_data    (tot_data)
   );

   roi_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (tot_valid),
      .push_ready (tot_ready),
      .push_data  (tot_data),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   roi_back u_back (
      .clock        (clock),
      .reset        (reset),
      .tot_valid    (q_valid),
      .tot_ready    (q_ready),
      .tot_data     (q_data),
      .out_valid    (rsp_chan.valid),
      .out_ready    (rsp_chan.ready),
      .mean_gray    (rsp_chan.mean_gray),
      .sample_count (rsp_chan.sample_count),
      .region_empty (rsp_chan.region_empty)
   );

endmodule

[design/roi_checker.sv]
// Port-level checks on the result channel of the region mean gray block,
// bound to the top level. Depends on roi_mean_gray_strided_assert.svh.
`include "roi_mean_gray_strided_assert.svh"

module roi_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  mean_gray,
   input logic [20:0] sample_count,
   input logic        region_empty
);

   // A stalled result keeps its value
   `ROI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(mean_gray) && $stable(sample_count) && $stable(region_empty))

   // Empty flag agrees with the count
   `ROI_ASSERT_NOW(a_empty_matches_count, clock, reset, rsp_valid, region_empty == (sample_count == 21'd0))

   // No samples means a zero mean
   `ROI_ASSERT_NOW(a_empty_zero_mean, clock, reset, rsp_valid && region_empty, mean_gray == 8'd0)

   // Nothing offered straight out of reset
   `ROI_ASSERT_NOW(a_quiet_after_reset, clock, reset, $past(reset), !rsp_valid)

endmodule

bind roi_mean_gray_strided roi_checker u_roi_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_chan.valid),
   .rsp_ready    (rsp_chan.ready),
   .mean_gray    (rsp_chan.mean_gray),
   .sample_count (rsp_chan.sample_count),
   .region_empty (rsp_chan.region_empty)
);
